>>> sv/epad_pkg.sv
// Shared types, constants and the operation sequence ROM for the Edwards point unit.
// Used by the top level and the testbench.
package epad_pkg;

    // Action codes of a command transaction.
    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_ADD      = 2'd1;
    localparam logic [1:0] ACT_DBL      = 2'd2;
    localparam logic [1:0] ACT_DBL_NO_T = 2'd3;

    // Load target that writes nothing.
    localparam logic [2:0] SEL_NONE = 3'd7;

    // Field element slots in the working store, four 64-bit words each.
    localparam logic [3:0] EL_X  = 4'd0;
    localparam logic [3:0] EL_Y  = 4'd1;
    localparam logic [3:0] EL_T  = 4'd2;
    localparam logic [3:0] EL_Z  = 4'd3;
    localparam logic [3:0] EL_QP = 4'd4;
    localparam logic [3:0] EL_QM = 4'd5;
    localparam logic [3:0] EL_Q2 = 4'd6;
    localparam logic [3:0] EL_A  = 4'd7;
    localparam logic [3:0] EL_B  = 4'd8;
    localparam logic [3:0] EL_C  = 4'd9;
    localparam logic [3:0] EL_D  = 4'd10;
    localparam logic [3:0] EL_E  = 4'd11;
    localparam logic [3:0] EL_F  = 4'd12;
    localparam logic [3:0] EL_G  = 4'd13;
    localparam logic [3:0] EL_H  = 4'd14;

    localparam int WORD_W    = 64;
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW  = 6;

    // Last step of each sequence; the doubling without T stops before the T product.
    localparam logic [3:0] STEP_LAST      = 4'd13;
    localparam logic [3:0] STEP_LAST_NO_T = 4'd12;

    // Field prime 2^255 - 19.
    localparam logic [255:0] PRIME = {1'b0, {250{1'b1}}, 5'b01101};

    // Operand phases of one step.
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_R = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] dst;
        logic [3:0] src_a;
        logic [3:0] src_b;
    } uop_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_NORM,
        ST_EXEC,
        ST_MUL_P,
        ST_MUL_A,
        ST_MUL_F,
        ST_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    function automatic uop_t mk(op_t op, logic [3:0] d, logic [3:0] a, logic [3:0] b);
        uop_t u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        return u;
    endfunction

    // Address bit 4 selects the doubling sequence, bits 3:0 the step.
    function automatic uop_t uop_rom(logic [4:0] addr);
        uop_t u;
        case (addr)
            5'd0:  u = mk(OP_SUB, EL_A, EL_Y, EL_X);
            5'd1:  u = mk(OP_MUL, EL_A, EL_A, EL_QM);
            5'd2:  u = mk(OP_ADD, EL_B, EL_Y, EL_X);
            5'd3:  u = mk(OP_MUL, EL_B, EL_B, EL_QP);
            5'd4:  u = mk(OP_MUL, EL_C, EL_T, EL_Q2);
            5'd5:  u = mk(OP_ADD, EL_D, EL_Z, EL_Z);
            5'd6:  u = mk(OP_SUB, EL_E, EL_B, EL_A);
            5'd7:  u = mk(OP_SUB, EL_F, EL_D, EL_C);
            5'd8:  u = mk(OP_ADD, EL_G, EL_D, EL_C);
            5'd9:  u = mk(OP_ADD, EL_H, EL_B, EL_A);
            5'd16: u = mk(OP_MUL, EL_A, EL_X, EL_X);
            5'd17: u = mk(OP_MUL, EL_B, EL_Y, EL_Y);
            5'd18: u = mk(OP_MUL, EL_C, EL_Z, EL_Z);
            5'd19: u = mk(OP_ADD, EL_C, EL_C, EL_C);
            5'd20: u = mk(OP_ADD, EL_D, EL_X, EL_Y);
            5'd21: u = mk(OP_MUL, EL_D, EL_D, EL_D);
            5'd22: u = mk(OP_ADD, EL_H, EL_A, EL_B);
            5'd23: u = mk(OP_SUB, EL_G, EL_A, EL_B);
            5'd24: u = mk(OP_SUB, EL_E, EL_H, EL_D);
            5'd25: u = mk(OP_ADD, EL_F, EL_G, EL_C);
            5'd10, 5'd26: u = mk(OP_MUL, EL_X, EL_E, EL_F);
            5'd11, 5'd27: u = mk(OP_MUL, EL_Y, EL_G, EL_H);
            5'd12, 5'd28: u = mk(OP_MUL, EL_Z, EL_F, EL_G);
            5'd13, 5'd29: u = mk(OP_MUL, EL_T, EL_E, EL_H);
            default: u = mk(OP_ADD, EL_A, EL_A, EL_A);
        endcase
        return u;
    endfunction

endpackage

>>> sv/epad_if.sv
// Handshake channel interfaces of the Edwards point unit: command and response.
// Depends on nothing; payload widths are fixed by the transaction format.
interface epad_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  coord_sel;
    logic [1:0]  word_index;
    logic [63:0] load_data;

    modport source (output valid, action, coord_sel, word_index, load_data, input ready);
    modport sink (input valid, action, coord_sel, word_index, load_data, output ready);
endinterface

interface epad_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_coord;
    logic [1:0]  out_word;
    logic [63:0] out_data;
    logic        out_last;

    modport source (output valid, out_coord, out_word, out_data, out_last, input ready);
    modport sink (input valid, out_coord, out_word, out_data, out_last, output ready);
endinterface

>>> sv/epad_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module epad_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/edwards_point_add_double_unit.sv
// Top level of the Edwards point unit: sequencer, field arithmetic datapath and word store.
// Depends on epad_pkg, the channel interfaces in epad_if.sv and epad_ram.
//
// Use: commands arrive on cmd as transactions. A load writes one 64-bit word of
// point P (X, Y, T, Z) or of the precomputed point Q (y+x, y-x, 2dt);
// cmd.ready is high again on the next cycle. An add, double or
// double-without-T runs a fixed sequence of field operations on the word store
// and then returns the new coordinates on rsp as 64-bit words, least significant
// word first, X, Y, T, Z (T omitted for the double without T), with out_last on
// the final word of Z. Every word is fully reduced below 2^255 - 19 and is also
// written back into P, so operations chain.
// Each field operation reads its two operands word by word from the RAM and
// reduces them, computes, reduces and writes back. A field product runs on one
// 32x32 multiplier, forming its 64 partial products one after another. Each
// result word is read from the store and then offered on rsp.
// No command is taken while a point operation runs or results are pending.
// If the receiver stalls, the current result word is held on rsp until taken.
// Reset clears the sequencer and marks P and Q as zero; no clearing pass is needed.
module edwards_point_add_double_unit (
    input logic            clk,
    input logic            rst_n,
    epad_cmd_if.sink       cmd,
    epad_rsp_if.source     rsp
);

    epad_pkg::state_t state_reg;
    epad_pkg::state_t state_next;

    logic [2:0]   cnt_reg;
    logic [2:0]   cnt_next;
    logic [1:0]   phase_reg;
    logic [1:0]   phase_next;
    logic [4:0]   pc_reg;
    logic [4:0]   pc_next;
    logic [3:0]   last_reg;
    logic [3:0]   last_next;
    logic         no_t_reg;
    logic         no_t_next;
    logic [2:0]   i_reg;
    logic [2:0]   i_next;
    logic [2:0]   j_reg;
    logic [2:0]   j_next;
    logic [3:0]   ecnt_reg;
    logic [3:0]   ecnt_next;

    // Words of slots 0 to 7 (P, Q and A) written since reset; unwritten ones there read as zero.
    logic [31:0]  valid_reg;
    logic         rvalid_reg;

    logic [261:0] w_reg;
    logic [255:0] opa_reg;
    logic [255:0] opb_reg;
    logic [511:0] t_reg;
    logic [63:0]  prod_reg;
    logic [31:0]  carry_reg;

    logic                          mem_we;
    logic [epad_pkg::STORE_AW-1:0] mem_waddr;
    logic [epad_pkg::WORD_W-1:0]   mem_wdata;
    logic                          mem_re;
    logic [epad_pkg::STORE_AW-1:0] mem_raddr;
    logic [epad_pkg::WORD_W-1:0]   mem_rdata;
    logic [63:0]                   rword;

    epad_pkg::uop_t uop;
    logic [3:0]     src_el;
    logic [1:0]     widx;
    logic [261:0]   norm_w;
    logic [11:0]    fold_hi;
    logic [255:0]   plus19;
    logic [261:0]   mul_fold;
    logic [63:0]    mac;
    logic [3:0]     tcol;

    epad_ram #(
        .WIDTH (epad_pkg::WORD_W),
        .DEPTH (epad_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rword  = rvalid_reg ? mem_rdata : 64'd0;
    assign uop    = epad_pkg::uop_rom(pc_reg);
    assign src_el = (phase_reg == epad_pkg::PH_A) ? uop.src_a : uop.src_b;
    assign widx   = 2'(cnt_reg - 3'd1);

    // Reduction in four steps: fold bits above 2^256 twice by 38, fold bit 255 by 19,
    // then subtract p once if the value is still at or above it.
    assign fold_hi = {6'd0, w_reg[261:256]} * 12'd38;
    assign plus19  = w_reg[255:0] + 256'd19;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    norm_w = {6'd0, w_reg[255:0]} + {250'd0, fold_hi};
            2'd1:    norm_w = {6'd0, w_reg[255:0]} + (w_reg[256] ? 262'd38 : 262'd0);
            2'd2:    norm_w = {7'd0, w_reg[254:0]} + (w_reg[255] ? 262'd19 : 262'd0);
            default: norm_w = plus19[255] ? {7'd0, plus19[254:0]} : w_reg;
        endcase
    end

    // High half of the 512-bit product folds in as 38 times, since 2^256 = 38 mod p.
    assign mul_fold = {6'd0, t_reg[255:0]}
                    + {1'b0, t_reg[511:256], 5'd0}
                    + {4'd0, t_reg[511:256], 2'd0}
                    + {5'd0, t_reg[511:256], 1'b0};

    assign tcol = {1'b0, i_reg} + {1'b0, j_reg};
    assign mac  = prod_reg + {32'd0, t_reg[32*tcol +: 32]} + {32'd0, carry_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= epad_pkg::ST_IDLE;
            cnt_reg    <= 3'd0;
            phase_reg  <= epad_pkg::PH_A;
            pc_reg     <= 5'd0;
            last_reg   <= epad_pkg::STEP_LAST;
            no_t_reg   <= 1'b0;
            i_reg      <= 3'd0;
            j_reg      <= 3'd0;
            ecnt_reg   <= 4'd0;
            valid_reg  <= 32'd0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            last_reg  <= last_next;
            no_t_reg  <= no_t_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ecnt_reg  <= ecnt_next;
            if (mem_we && !mem_waddr[5])
            begin
                valid_reg[mem_waddr[4:0]] <= 1'b1;
            end
            if (mem_re)
            begin
                rvalid_reg <= mem_raddr[5] | valid_reg[mem_raddr[4:0]];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        pc_next    = pc_reg;
        last_next  = last_reg;
        no_t_next  = no_t_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ecnt_next  = ecnt_reg;
        mem_we     = 1'b0;
        mem_waddr  = {uop.dst, cnt_reg[1:0]};
        mem_wdata  = w_reg[64*cnt_reg[1:0] +: 64];
        mem_re     = 1'b0;
        mem_raddr  = {src_el, cnt_reg[1:0]};
        cmd.ready  = 1'b0;
        rsp.valid  = 1'b0;

        case (state_reg)
            epad_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    if (cmd.action == epad_pkg::ACT_LOAD)
                    begin
                        mem_we    = (cmd.coord_sel != epad_pkg::SEL_NONE);
                        mem_waddr = {1'b0, cmd.coord_sel, cmd.word_index};
                        mem_wdata = cmd.load_data;
                    end
                    else
                    begin
                        pc_next    = {cmd.action != epad_pkg::ACT_ADD, 4'd0};
                        no_t_next  = (cmd.action == epad_pkg::ACT_DBL_NO_T);
                        last_next  = (cmd.action == epad_pkg::ACT_DBL_NO_T)
                                   ? epad_pkg::STEP_LAST_NO_T : epad_pkg::STEP_LAST;
                        phase_next = epad_pkg::PH_A;
                        cnt_next   = 3'd0;
                        state_next = epad_pkg::ST_RD;
                    end
                end
            end

            epad_pkg::ST_RD:
            begin
                mem_re = (cnt_reg != 3'd4);
                if (cnt_reg == 3'd4)
                begin
                    cnt_next   = 3'd0;
                    state_next = epad_pkg::ST_NORM;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            epad_pkg::ST_NORM:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    cnt_next = 3'd0;
                    case (phase_reg)
                        epad_pkg::PH_A:
                        begin
                            phase_next = epad_pkg::PH_B;
                            state_next = epad_pkg::ST_RD;
                        end
                        epad_pkg::PH_B:
                        begin
                            state_next = epad_pkg::ST_EXEC;
                        end
                        default:
                        begin
                            state_next = epad_pkg::ST_WR;
                        end
                    endcase
                end
            end

            epad_pkg::ST_EXEC:
            begin
                phase_next = epad_pkg::PH_R;
                cnt_next   = 3'd0;
                i_next     = 3'd0;
                j_next     = 3'd0;
                state_next = (uop.op == epad_pkg::OP_MUL) ? epad_pkg::ST_MUL_P
                                                          : epad_pkg::ST_NORM;
            end

            epad_pkg::ST_MUL_P:
            begin
                state_next = epad_pkg::ST_MUL_A;
            end

            epad_pkg::ST_MUL_A:
            begin
                j_next     = j_reg + 3'd1;
                state_next = epad_pkg::ST_MUL_P;
                if (j_reg == 3'd7)
                begin
                    i_next = i_reg + 3'd1;
                    if (i_reg == 3'd7)
                    begin
                        state_next = epad_pkg::ST_MUL_F;
                    end
                end
            end

            epad_pkg::ST_MUL_F:
            begin
                cnt_next   = 3'd0;
                state_next = epad_pkg::ST_NORM;
            end

            epad_pkg::ST_WR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    cnt_next   = 3'd0;
                    phase_next = epad_pkg::PH_A;
                    if (pc_reg[3:0] == last_reg)
                    begin
                        ecnt_next  = 4'd0;
                        state_next = epad_pkg::ST_EMIT_RD;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 5'd1;
                        state_next = epad_pkg::ST_RD;
                    end
                end
            end

            epad_pkg::ST_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {2'd0, ecnt_reg};
                state_next = epad_pkg::ST_EMIT_OUT;
            end

            epad_pkg::ST_EMIT_OUT:
            begin
                // The RAM read register holds the word while the receiver stalls.
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    if (ecnt_reg == 4'd15)
                    begin
                        state_next = epad_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ecnt_next  = (no_t_reg && ecnt_reg == 4'd7) ? 4'd12
                                                                    : ecnt_reg + 4'd1;
                        state_next = epad_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = epad_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.out_coord = ecnt_reg[3:2];
    assign rsp.out_word  = ecnt_reg[1:0];
    assign rsp.out_data  = rword;
    assign rsp.out_last  = (ecnt_reg == 4'd15);

    // Arithmetic datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            epad_pkg::ST_RD:
            begin
                if (cnt_reg == 3'd0)
                begin
                    w_reg <= 262'd0;
                end
                else
                begin
                    w_reg[64*widx +: 64] <= rword;
                end
            end

            epad_pkg::ST_NORM:
            begin
                w_reg <= norm_w;
                if (cnt_reg == 3'd3 && phase_reg == epad_pkg::PH_A)
                begin
                    opa_reg <= norm_w[255:0];
                end
                if (cnt_reg == 3'd3 && phase_reg == epad_pkg::PH_B)
                begin
                    opb_reg <= norm_w[255:0];
                end
            end

            epad_pkg::ST_EXEC:
            begin
                t_reg     <= 512'd0;
                carry_reg <= 32'd0;
                if (uop.op == epad_pkg::OP_SUB)
                begin
                    w_reg <= {6'd0, opa_reg} + {6'd0, epad_pkg::PRIME} - {6'd0, opb_reg};
                end
                else
                begin
                    w_reg <= {6'd0, opa_reg} + {6'd0, opb_reg};
                end
            end

            epad_pkg::ST_MUL_P:
            begin
                prod_reg <= {32'd0, opa_reg[32*i_reg +: 32]} * {32'd0, opb_reg[32*j_reg +: 32]};
            end

            epad_pkg::ST_MUL_A:
            begin
                t_reg[32*tcol +: 32] <= mac[31:0];
                if (j_reg == 3'd7)
                begin
                    t_reg[32*{1'b1, i_reg} +: 32] <= mac[63:32];
                    carry_reg <= 32'd0;
                end
                else
                begin
                    carry_reg <= mac[63:32];
                end
            end

            epad_pkg::ST_MUL_F:
            begin
                w_reg <= mul_fold;
            end

            default:
            begin
            end
        endcase
    end

endmodule

>>> sim/tb_edwards_point_add_double_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the Edwards point unit: directed table, then random point runs.
// Depends on epad_pkg, the channel interfaces in epad_if.sv and the unit's top level.
module tb_edwards_point_add_double_unit;

    // One command transaction, with a flag for rows whose result is known to be all zero.
    typedef struct {
        logic [1:0]  act;
        logic [2:0]  sel;
        logic [1:0]  wi;
        logic [63:0] data;
        bit          all_zero;
    } point_cmd_t;

    // One result word as it should appear on the response channel.
    typedef struct {
        logic [1:0]  coord;
        logic [1:0]  word;
        logic [63:0] data;
        logic        last;
    } coord_word_t;

    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 400;

    localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] P_LOW = 64'hFFFF_FFFF_FFFF_FFED;
    localparam logic [63:0] P_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    // Directed stimulus. The first three rows run on the cleared point, so every
    // coordinate they return is zero. Afterwards P gets an all-ones X (above p),
    // Q gets its three coordinates, an out-of-range load target is tried and all
    // three point operations run; then X is loaded with p, which must reduce to zero.
    point_cmd_t directed [N_DIRECTED] = '{
        '{epad_pkg::ACT_DBL,      3'd0, 2'd0, 64'd0, 1'b1},
        '{epad_pkg::ACT_ADD,      3'd5, 2'd3, ONES,  1'b1},
        '{epad_pkg::ACT_DBL_NO_T, 3'd7, 2'd1, ONES,  1'b1},
        '{epad_pkg::ACT_LOAD,     3'd0, 2'd0, ONES,  1'b0},
        '{epad_pkg::ACT_LOAD,     3'd0, 2'd1, ONES,  1'b0},
        '{epad_pkg::ACT_LOAD,     3'd0, 2'd2, ONES,  1'b0},
        '{epad_pkg::ACT_LOAD,     3'd0, 2'd3, ONES,  1'b0},
        '{epad_pkg::ACT_LOAD,     3'd1, 2'd0, 64'd5, 1'b0},
        '{epad_pkg::ACT_LOAD,     3'd3, 2'd0, 64'd1, 1'b0},
        '{epad_pkg::ACT_LOAD,     3'd2, 2'd3, ONES,  1'b0},
        '{epad_pkg::ACT_LOAD,     3'd4, 2'd0, 64'd1, 1'b0},
        '{epad_pkg::ACT_LOAD,     3'd5, 2'd0, ONES,  1'b0},
        '{epad_pkg::ACT_LOAD,     3'd6, 2'd2, 64'h0123_4567_89AB_CDEF, 1'b0},
        '{epad_pkg::ACT_LOAD,     epad_pkg::SEL_NONE, 2'd1, ONES, 1'b0},
        '{epad_pkg::ACT_ADD,      3'd0, 2'd0, 64'd0, 1'b0},
        '{epad_pkg::ACT_DBL,      3'd0, 2'd0, 64'd0, 1'b0},
        '{epad_pkg::ACT_DBL_NO_T, 3'd0, 2'd0, 64'd0, 1'b0},
        '{epad_pkg::ACT_LOAD,     3'd0, 2'd0, P_LOW, 1'b0},
        '{epad_pkg::ACT_LOAD,     3'd0, 2'd1, ONES,  1'b0},
        '{epad_pkg::ACT_LOAD,     3'd0, 2'd2, ONES,  1'b0},
        '{epad_pkg::ACT_LOAD,     3'd0, 2'd3, P_TOP, 1'b0},
        '{epad_pkg::ACT_ADD,      3'd0, 2'd0, 64'd0, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    epad_cmd_if cmd ();
    epad_rsp_if rsp ();

    edwards_point_add_double_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Predictor state: the words of P and Q exactly as loaded or written back.
    logic [63:0] p_words [16];
    logic [63:0] q_words [12];

    point_cmd_t  stimulus [$];
    coord_word_t pending_words [$];
    int          n_mismatch = 0;
    int          n_accepted = 0;

    // Field arithmetic modulo p on wide vectors, so that no carry is ever lost.
    function automatic logic [254:0] fe_reduce(input logic [511:0] v);
        logic [511:0] r;
        r = v % {256'd0, epad_pkg::PRIME};
        return r[254:0];
    endfunction

    function automatic logic [254:0] fe_from_words(input logic [63:0] w0, input logic [63:0] w1,
                                                   input logic [63:0] w2, input logic [63:0] w3);
        return fe_reduce({256'd0, w3, w2, w1, w0});
    endfunction

    function automatic logic [254:0] fe_add(input logic [254:0] a, input logic [254:0] b);
        return fe_reduce({257'd0, a} + {257'd0, b});
    endfunction

    function automatic logic [254:0] fe_sub(input logic [254:0] a, input logic [254:0] b);
        return fe_reduce({257'd0, a} + {256'd0, epad_pkg::PRIME} - {257'd0, b});
    endfunction

    function automatic logic [254:0] fe_mul(input logic [254:0] a, input logic [254:0] b);
        return fe_reduce({257'd0, a} * {257'd0, b});
    endfunction

    // Applies one accepted transaction to the predicted point state and queues
    // the result words that it should produce.
    task automatic predict_point_op(input point_cmd_t c);
        logic [254:0] x, y, t, z, a, b, cc, d, e, f, g, h, qp, qm, q2;
        logic [254:0] coord_val [4];
        logic [255:0] wide;
        coord_word_t  w;
        if (c.act == epad_pkg::ACT_LOAD)
        begin
            if (c.sel < 3'd4)
                p_words[c.sel * 4 + c.wi] = c.data;
            else if (c.sel != epad_pkg::SEL_NONE)
                q_words[(c.sel - 4) * 4 + c.wi] = c.data;
            return;
        end
        x = fe_from_words(p_words[0], p_words[1], p_words[2], p_words[3]);
        y = fe_from_words(p_words[4], p_words[5], p_words[6], p_words[7]);
        t = fe_from_words(p_words[8], p_words[9], p_words[10], p_words[11]);
        z = fe_from_words(p_words[12], p_words[13], p_words[14], p_words[15]);
        if (c.act == epad_pkg::ACT_ADD)
        begin
            qp = fe_from_words(q_words[0], q_words[1], q_words[2], q_words[3]);
            qm = fe_from_words(q_words[4], q_words[5], q_words[6], q_words[7]);
            q2 = fe_from_words(q_words[8], q_words[9], q_words[10], q_words[11]);
            a  = fe_mul(fe_sub(y, x), qm);
            b  = fe_mul(fe_add(y, x), qp);
            cc = fe_mul(t, q2);
            d  = fe_add(z, z);
            e  = fe_sub(b, a);
            f  = fe_sub(d, cc);
            g  = fe_add(d, cc);
            h  = fe_add(b, a);
        end
        else
        begin
            a  = fe_mul(x, x);
            b  = fe_mul(y, y);
            cc = fe_mul(z, z);
            cc = fe_add(cc, cc);
            d  = fe_add(x, y);
            d  = fe_mul(d, d);
            h  = fe_add(a, b);
            g  = fe_sub(a, b);
            e  = fe_sub(h, d);
            f  = fe_add(g, cc);
        end
        coord_val[0] = fe_mul(e, f);
        coord_val[1] = fe_mul(g, h);
        coord_val[2] = (c.act == epad_pkg::ACT_DBL_NO_T) ? t : fe_mul(e, h);
        coord_val[3] = fe_mul(f, g);
        for (int k = 0; k < 4; k++)
        begin
            // The doubling without T keeps the stored T words untouched.
            if (k == 2 && c.act == epad_pkg::ACT_DBL_NO_T)
                continue;
            wide = {1'b0, coord_val[k]};
            for (int j = 0; j < 4; j++)
            begin
                p_words[k * 4 + j] = wide[j * 64 +: 64];
                w.coord = k[1:0];
                w.word  = j[1:0];
                w.data  = c.all_zero ? 64'd0 : wide[j * 64 +: 64];
                w.last  = (k == 3 && j == 3);
                pending_words.push_back(w);
            end
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("t=%0t %s: got %h, expected %h", $realtime, what, got, want);
        n_mismatch++;
    endtask

    // Operand words: mostly random, with a share of extremes and of words near p.
    function automatic logic [63:0] pick_word(input int wi);
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return ONES;
            2: return (wi == 3) ? P_TOP : ((wi == 0) ? P_LOW - $urandom_range(0, 3) : ONES);
            3: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic add_cmd(input logic [1:0] act, input logic [2:0] sel, input logic [1:0] wi,
                           input logic [63:0] data);
        point_cmd_t c;
        c.act = act;
        c.sel = sel;
        c.wi = wi;
        c.data = data;
        c.all_zero = 1'b0;
        stimulus.push_back(c);
    endtask

    // Builds the whole stimulus list: the directed table, then random runs. Most
    // runs reload part or all of P and Q and chain one to three point operations;
    // the rest are loose transactions with random fields, out-of-range targets included.
    initial
    begin
        int n_rand;
        int n_ops;
        foreach (directed[i])
            stimulus.push_back(directed[i]);
        n_rand = 0;
        while (n_rand < N_RANDOM)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                for (int s = 0; s < 7; s++)
                    for (int j = 0; j < 4; j++)
                        if ($urandom_range(0, 2) != 0)
                        begin
                            add_cmd(epad_pkg::ACT_LOAD, s[2:0], j[1:0], pick_word(j));
                            n_rand++;
                        end
                n_ops = $urandom_range(1, 3);
                for (int k = 0; k < n_ops; k++)
                begin
                    add_cmd(2'($urandom_range(1, 3)), 3'($urandom()), 2'($urandom()),
                            {$urandom(), $urandom()});
                    n_rand++;
                end
            end
            else
            begin
                add_cmd(2'($urandom()), 3'($urandom()), 2'($urandom()), pick_word(0));
                n_rand++;
            end
        end
    end

    // Command sender: bursts of random length separated by random gaps. The
    // payload is held steady while a transaction waits for ready.
    initial
    begin
        int burst_left;
        int gap_left;
        bit taken;
        cmd.valid      <= 1'b0;
        cmd.action     <= epad_pkg::ACT_LOAD;
        cmd.coord_sel  <= epad_pkg::SEL_NONE;
        cmd.word_index <= 2'd0;
        cmd.load_data  <= 64'd0;
        for (int i = 0; i < 16; i++)
            p_words[i] = 64'd0;
        for (int i = 0; i < 12; i++)
            q_words[i] = 64'd0;
        burst_left = 1;
        gap_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        forever
        begin
            @(posedge clk);
            taken = cmd.valid && cmd.ready;
            if (taken)
            begin
                predict_point_op(stimulus[n_accepted]);
                n_accepted++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            if (!cmd.valid || taken)
            begin
                if (gap_left > 0 || n_accepted >= stimulus.size())
                begin
                    if (gap_left > 0)
                        gap_left--;
                    cmd.valid      <= 1'b0;
                    cmd.action     <= 2'($urandom());
                    cmd.coord_sel  <= 3'($urandom());
                    cmd.word_index <= 2'($urandom());
                    cmd.load_data  <= {$urandom(), $urandom()};
                end
                else
                begin
                    cmd.valid      <= 1'b1;
                    cmd.action     <= stimulus[n_accepted].act;
                    cmd.coord_sel  <= stimulus[n_accepted].sel;
                    cmd.word_index <= stimulus[n_accepted].wi;
                    cmd.load_data  <= stimulus[n_accepted].data;
                end
            end
        end
    end

    // Response receiver: the stall pattern is drawn at random anew for each stretch of the run:
    // always ready, light random stalls or long stretches held off.
    initial
    begin
        int stall_mode;
        int cycle_in_mode;
        rsp.ready <= 1'b0;
        stall_mode = 0;
        cycle_in_mode = 0;
        forever
        begin
            @(posedge clk);
            if (cycle_in_mode == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                cycle_in_mode = $urandom_range(50, 400);
            end
            cycle_in_mode--;
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 3) != 0);
                default: rsp.ready <= ((cycle_in_mode % 16) < 3);
            endcase
        end
    end

    // Result checker: every transaction on rsp is compared with the oldest
    // predicted word.
    always @(posedge clk)
    begin
        coord_word_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_words.size() == 0)
            begin
                report("unexpected result word", rsp.out_data, 64'd0);
            end
            else
            begin
                want = pending_words.pop_front();
                if (rsp.out_coord != want.coord)
                    report("out_coord", 64'(rsp.out_coord), 64'(want.coord));
                if (rsp.out_word != want.word)
                    report("out_word", 64'(rsp.out_word), 64'(want.word));
                if (rsp.out_data != want.data)
                    report("out_data", rsp.out_data, want.data);
                if (rsp.out_last != want.last)
                    report("out_last", 64'(rsp.out_last), 64'(want.last));
            end
        end
    end

    // End of run: all stimulus taken, all predicted words seen, then a short
    // drain in case a stray word follows.
    initial
    begin
        wait (rst_n);
        while (stimulus.size() == 0 || n_accepted < stimulus.size() || pending_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (pending_words.size() != 0)
            report("result words never delivered", 64'(pending_words.size()), 64'd0);
        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
sv/epad_pkg.sv
sv/epad_if.sv
sv/epad_ram.sv
sv/edwards_point_add_double_unit.sv
sim/tb_edwards_point_add_double_unit.sv
